// File: src/jtt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtt_pkg: shared types and constants of the job timer table
// Holds operation, status and result codes plus the default slot count.
// ----------------------------------------------------------------------------
package jtt_pkg;

  localparam int SlotCountDefault = 16;

  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_ONE_SHOT = 3'd1;
  localparam logic [2:0] OP_PERIODIC = 3'd2;
  localparam logic [2:0] OP_DAILY    = 3'd3;
  localparam logic [2:0] OP_CANCEL   = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD      = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  localparam logic [1:0] KIND_SETUP  = 2'd0;
  localparam logic [1:0] KIND_FIRED  = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  localparam logic [31:0] SecPerDay = 32'd86400;

  // Epoch split into day and second of day.
  typedef struct packed {
    logic [31:0] day;
    logic [16:0] sec;
  } day_split_t;

endpackage

// File: src/jtt_day_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtt_day_div: split of the epoch into day and second of day
// Reciprocal multiply for the day, then a multiply-back for the remainder;
// done is registered together with sec_q, so the result is valid while done is high.
// ----------------------------------------------------------------------------
module jtt_day_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic [31:0]         dividend,
  output logic                done,
  output jtt_pkg::day_split_t result
);

  // 2^35 / 675 rounded up; exact quotient for any 25-bit numerator.
  localparam logic [25:0] RecipDay = 26'd50903317;

  logic [31:0] num;
  logic [50:0] prod;
  logic [15:0] day_q;
  logic [16:0] sec_q;
  logic [2:0]  phase;
  logic [32:0] day_secs;

  assign day_secs = 33'(day_q) * 33'(jtt_pkg::SecPerDay);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      done  <= 1'b0;
    end else begin
      phase <= {phase[1:0], go};
      done  <= phase[2];
    end
  end

  // 86400 is 128 times 675, so the low seven bits drop out before the multiply.
  always_ff @(posedge clk) begin
    if (go) num <= dividend;
    if (phase[0]) prod <= 51'(num[31:7]) * 51'(RecipDay);
    if (phase[1]) day_q <= prod[50:35];
    if (phase[2]) sec_q <= 17'(num - day_secs[31:0]);
  end

  assign result.day = {16'd0, day_q};
  assign result.sec = sec_q;

endmodule

// File: src/job_timer_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// job_timer_table: table of one-shot, periodic and daily jobs
// Set-up items add or cancel jobs; a tick fires the jobs that are due.
// ----------------------------------------------------------------------------
// Channel | Signals                                         | Handshake
// input   | op job_id time_value hour_utc minute_utc        | start & !busy
//         | now_ms wall_valid epoch_seconds                 |
// result  | kind status fired_job_id last                   | strobe
//
// A set-up checks one slot per cycle in S_SCAN with the shared compare unit,
// then the table is written and the status is shown in S_WRITE.
// A tick waits in S_DIV for the day split, scans one slot per cycle in
// S_TICK, then gives the closing beat in S_DONE.
// Reset clears every slot's used flag; the block is ready the cycle after.
// Results cannot be stalled; each beat lasts one cycle.
// ----------------------------------------------------------------------------
module job_timer_table #(
  parameter int SLOT_COUNT = jtt_pkg::SlotCountDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  op,
  input  logic [7:0]  job_id,
  input  logic [31:0] time_value,
  input  logic [7:0]  hour_utc,
  input  logic [7:0]  minute_utc,
  input  logic [31:0] now_ms,
  input  logic        wall_valid,
  input  logic [31:0] epoch_seconds,
  output logic        strobe,
  output logic [1:0]  kind,
  output logic [2:0]  status,
  output logic [7:0]  fired_job_id,
  output logic        last
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_WRITE = 6'b000100,
    S_DIV   = 6'b001000,
    S_TICK  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;

  logic [SLOT_COUNT-1:0] used;
  logic [SLOT_COUNT-1:0] wallc;
  logic [SLOT_COUNT-1:0] rep;
  logic [SLOT_COUNT-1:0] primed;
  logic [7:0]  id_mem   [SLOT_COUNT];
  logic [31:0] due_mem  [SLOT_COUNT];
  logic [30:0] ivl_mem  [SLOT_COUNT];
  logic [16:0] sod_mem  [SLOT_COUNT];
  logic [31:0] lday_mem [SLOT_COUNT];

  logic [2:0]  r_op;
  logic [7:0]  r_id;
  logic [31:0] r_tv;
  logic [16:0] r_sod;
  logic [31:0] r_now;
  logic        r_wall;
  logic        bad;
  logic [CW-1:0] idx;
  logic [IW-1:0] slot;
  logic        found;
  logic [IW-1:0] match_slot;
  logic        have_free;
  logic [IW-1:0] free_slot;

  logic        div_go;
  logic        div_done;
  jtt_pkg::day_split_t split;

  assign slot = idx[IW-1:0];

  jtt_day_div u_div (
    .clk(clk), .rst(rst), .go(div_go), .dividend(epoch_seconds),
    .done(div_done), .result(split)
  );

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign div_go = accept && (op == jtt_pkg::OP_TICK);

  // Argument check of a set-up item.
  logic in_bad;
  always_comb begin
    case (op)
      jtt_pkg::OP_ONE_SHOT: in_bad = (job_id == 8'd0) || time_value[31];
      jtt_pkg::OP_PERIODIC: in_bad = (job_id == 8'd0) || time_value[31] ||
                                     (time_value == 32'd0);
      jtt_pkg::OP_DAILY:    in_bad = (job_id == 8'd0) || (hour_utc > 8'd23) ||
                                     (minute_utc > 8'd59);
      jtt_pkg::OP_CANCEL:   in_bad = (job_id == 8'd0);
      default:              in_bad = 1'b1;
    endcase
  end

  // Per-slot tick decision for the current slot.
  logic [31:0] diff;
  logic        mono_due;
  logic        sec_ge;
  logic [31:0] lday_eff;
  logic        day_fire;
  logic        fire;
  assign diff     = r_now - due_mem[slot];
  assign mono_due = !diff[31];
  assign sec_ge   = split.sec >= sod_mem[slot];
  assign lday_eff = primed[slot] ? lday_mem[slot]
                  : (sec_ge ? split.day : split.day - 32'd1);
  assign day_fire = r_wall && sec_ge && (lday_eff != split.day);
  assign fire     = used[slot] && (wallc[slot] ? day_fire : mono_due);

  logic [16:0] sod_calc;
  assign sod_calc = 17'(hour_utc[4:0]) * 17'd3600 + 17'(minute_utc[5:0]) * 17'd60;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      used   <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            idx   <= '0;
            found <= 1'b0;
            have_free <= 1'b0;
            state <= (op == jtt_pkg::OP_TICK) ? S_DIV : S_SCAN;
          end
        end
        S_SCAN: begin
          if (used[slot] && id_mem[slot] == r_id && !found) begin
            found      <= 1'b1;
            match_slot <= slot;
          end
          if (!used[slot] && !have_free) begin
            have_free <= 1'b1;
            free_slot <= slot;
          end
          idx <= idx + CW'(1);
          if (idx == CW'(SLOT_COUNT - 1)) state <= S_WRITE;
        end
        S_WRITE: begin
          strobe       <= 1'b1;
          kind         <= jtt_pkg::KIND_SETUP;
          fired_job_id <= 8'd0;
          last         <= 1'b1;
          state        <= S_IDLE;
          if (r_op == jtt_pkg::OP_CANCEL) begin
            if (!bad && found) begin
              used[match_slot] <= 1'b0;
              status <= jtt_pkg::ST_OK;
            end else begin
              status <= jtt_pkg::ST_NOTFOUND;
            end
          end else if (bad) begin
            status <= jtt_pkg::ST_BAD;
          end else if (found) begin
            status <= jtt_pkg::ST_DUP;
          end else if (!have_free) begin
            status <= jtt_pkg::ST_FULL;
          end else begin
            status <= jtt_pkg::ST_OK;
            used[free_slot] <= 1'b1;
          end
        end
        S_DIV: begin
          if (div_done) state <= S_TICK;
        end
        S_TICK: begin
          if (fire) begin
            strobe       <= 1'b1;
            kind         <= jtt_pkg::KIND_FIRED;
            status       <= jtt_pkg::ST_OK;
            fired_job_id <= id_mem[slot];
            last         <= 1'b0;
            if (!wallc[slot] && !rep[slot]) used[slot] <= 1'b0;
          end
          idx <= idx + CW'(1);
          if (idx == CW'(SLOT_COUNT - 1)) state <= S_DONE;
        end
        S_DONE: begin
          strobe       <= 1'b1;
          kind         <= jtt_pkg::KIND_DONE;
          status       <= jtt_pkg::ST_OK;
          fired_job_id <= 8'd0;
          last         <= 1'b1;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Captured item and slot payload writes.
  always_ff @(posedge clk) begin
    if (accept) begin
      r_op   <= op;
      r_id   <= job_id;
      r_tv   <= time_value;
      r_sod  <= sod_calc;
      r_now  <= now_ms;
      r_wall <= wall_valid;
      bad    <= in_bad;
    end
    if (state == S_WRITE && r_op != jtt_pkg::OP_CANCEL && !bad && !found &&
        have_free) begin
      id_mem[free_slot]   <= r_id;
      wallc[free_slot]    <= (r_op == jtt_pkg::OP_DAILY);
      rep[free_slot]      <= (r_op != jtt_pkg::OP_ONE_SHOT);
      primed[free_slot]   <= 1'b0;
      due_mem[free_slot]  <= r_now + r_tv;
      ivl_mem[free_slot]  <= r_tv[30:0];
      sod_mem[free_slot]  <= (r_op == jtt_pkg::OP_DAILY) ? r_sod : 17'd0;
      lday_mem[free_slot] <= '0;
    end
    if (state == S_TICK && used[slot]) begin
      if (!wallc[slot]) begin
        if (mono_due && rep[slot]) due_mem[slot] <= r_now + 32'(ivl_mem[slot]);
      end else if (r_wall) begin
        primed[slot]   <= 1'b1;
        lday_mem[slot] <= day_fire ? split.day : lday_eff;
      end
    end
  end

`ifndef ASSERT_OFF
  a_busy_strobe: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy) else $error("last beat while still busy");
  a_setup_last: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == jtt_pkg::KIND_SETUP |-> last) else $error("set-up beat not last");
  a_fired_id: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == jtt_pkg::KIND_FIRED |-> fired_job_id != 8'd0 && !last)
    else $error("fired beat with empty id");
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    state == S_TICK |-> $past(state == S_DIV) || $past(state == S_TICK))
    else $error("tick scan without division");
`endif

endmodule

// File: test/job_timer_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// job_timer_table_tb: self-checking bench for the job timer table
// Drives set-up and tick commands from a queue, predicts every result beat
// with an internal copy of the slot table and compares the beats in order.
// ----------------------------------------------------------------------------
module job_timer_table_tb;

  localparam int Slots = 16;
  localparam int WatchdogLimit = 20000;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  job_id;
    logic [31:0] time_value;
    logic [7:0]  hour_utc;
    logic [7:0]  minute_utc;
    logic [31:0] now_ms;
    logic        wall_valid;
    logic [31:0] epoch_seconds;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] status;
    logic [7:0] fired_job_id;
    logic       last;
  } beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0]  op = '0;
  logic [7:0]  job_id = '0;
  logic [31:0] time_value = '0;
  logic [7:0]  hour_utc = '0;
  logic [7:0]  minute_utc = '0;
  logic [31:0] now_ms = '0;
  logic        wall_valid = 1'b0;
  logic [31:0] epoch_seconds = '0;
  logic strobe;
  logic [1:0] kind;
  logic [2:0] status;
  logic [7:0] fired_job_id;
  logic last;

  job_timer_table #(.SLOT_COUNT(Slots)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .job_id(job_id),
    .time_value(time_value), .hour_utc(hour_utc), .minute_utc(minute_utc),
    .now_ms(now_ms), .wall_valid(wall_valid), .epoch_seconds(epoch_seconds),
    .strobe(strobe), .kind(kind), .status(status), .fired_job_id(fired_job_id),
    .last(last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predicted slot table.
  logic        tbl_used [Slots];
  logic [7:0]  tbl_id [Slots];
  logic        tbl_wall [Slots];
  logic        tbl_rep [Slots];
  logic [31:0] tbl_due [Slots];
  logic [30:0] tbl_ivl [Slots];
  logic [16:0] tbl_sod [Slots];
  logic [31:0] tbl_lastday [Slots];
  logic        tbl_primed [Slots];

  cmd_t  pending_cmds [$];
  beat_t expected_beats [$];
  int    mismatches = 0;
  int    idle_pct = 8;
  bit    hold_off = 1'b0;
  bit    stim_done = 1'b0;
  int    quiet_cycles = 0;

  function automatic void free_slot(int i);
    tbl_used[i] = 0; tbl_id[i] = 0; tbl_wall[i] = 0; tbl_rep[i] = 0;
    tbl_due[i] = 0; tbl_ivl[i] = 0; tbl_sod[i] = 0; tbl_lastday[i] = 0;
    tbl_primed[i] = 0;
  endfunction

  function automatic logic [2:0] add_job(logic [7:0] id, logic wall, logic rep,
                                         logic [31:0] due, logic [30:0] ivl,
                                         logic [16:0] sod);
    int spot;
    spot = -1;
    if (id == 0) return jtt_pkg::ST_BAD;
    for (int i = 0; i < Slots; i++)
      if (tbl_used[i] && tbl_id[i] == id) return jtt_pkg::ST_DUP;
    for (int i = 0; i < Slots; i++)
      if (!tbl_used[i] && spot < 0) spot = i;
    if (spot < 0) return jtt_pkg::ST_FULL;
    free_slot(spot);
    tbl_used[spot] = 1; tbl_id[spot] = id; tbl_wall[spot] = wall;
    tbl_rep[spot] = rep; tbl_due[spot] = due; tbl_ivl[spot] = ivl;
    tbl_sod[spot] = sod;
    return jtt_pkg::ST_OK;
  endfunction

  function automatic beat_t mk_beat(logic [1:0] k, logic [2:0] s, logic [7:0] id,
                                    logic l);
    beat_t b;
    b.kind = k; b.status = s; b.fired_job_id = id; b.last = l;
    return b;
  endfunction

  // Applies one command to the table and queues the beats it should produce.
  function automatic void predict_schedule(cmd_t c);
    logic [31:0] day, diff;
    logic [31:0] sec;
    logic [2:0]  st;
    if (c.op == jtt_pkg::OP_TICK) begin
      day = c.epoch_seconds / 32'd86400;
      sec = c.epoch_seconds % 32'd86400;
      for (int i = 0; i < Slots; i++) begin
        if (!tbl_used[i]) continue;
        if (!tbl_wall[i]) begin
          diff = c.now_ms - tbl_due[i];
          if (diff[31]) continue;
          expected_beats.push_back(mk_beat(jtt_pkg::KIND_FIRED, jtt_pkg::ST_OK,
                                           tbl_id[i], 1'b0));
          if (tbl_rep[i]) tbl_due[i] = c.now_ms + {1'b0, tbl_ivl[i]};
          else free_slot(i);
        end else begin
          if (!c.wall_valid) continue;
          if (!tbl_primed[i]) begin
            tbl_lastday[i] = (sec >= tbl_sod[i]) ? day : day - 32'd1;
            tbl_primed[i] = 1;
          end
          if (sec >= tbl_sod[i] && tbl_lastday[i] != day) begin
            tbl_lastday[i] = day;
            expected_beats.push_back(mk_beat(jtt_pkg::KIND_FIRED, jtt_pkg::ST_OK,
                                             tbl_id[i], 1'b0));
          end
        end
      end
      expected_beats.push_back(mk_beat(jtt_pkg::KIND_DONE, jtt_pkg::ST_OK, 8'd0, 1'b1));
      return;
    end
    case (c.op)
      jtt_pkg::OP_ONE_SHOT: st = c.time_value[31] ? jtt_pkg::ST_BAD
        : add_job(c.job_id, 1'b0, 1'b0, c.now_ms + c.time_value, '0, '0);
      jtt_pkg::OP_PERIODIC: st = (c.time_value == 0 || c.time_value[31]) ? jtt_pkg::ST_BAD
        : add_job(c.job_id, 1'b0, 1'b1, c.now_ms + c.time_value, c.time_value[30:0], '0);
      jtt_pkg::OP_DAILY: st = (c.hour_utc > 23 || c.minute_utc > 59) ? jtt_pkg::ST_BAD
        : add_job(c.job_id, 1'b1, 1'b1, '0, '0,
                  17'(c.hour_utc * 3600 + c.minute_utc * 60));
      jtt_pkg::OP_CANCEL: begin
        st = jtt_pkg::ST_NOTFOUND;
        if (c.job_id != 0)
          for (int i = 0; i < Slots; i++)
            if (st == jtt_pkg::ST_NOTFOUND && tbl_used[i] && tbl_id[i] == c.job_id)
            begin
              free_slot(i);
              st = jtt_pkg::ST_OK;
            end
      end
      default: st = jtt_pkg::ST_BAD;
    endcase
    expected_beats.push_back(mk_beat(jtt_pkg::KIND_SETUP, st, 8'd0, 1'b1));
  endfunction

  // Driver: one command per accepted beat, start held high back to back.
  always @(posedge clk) begin
    cmd_t c;
    if (!rst) begin
      if (start && !busy) predict_schedule({op, job_id, time_value, hour_utc,
                                            minute_utc, now_ms, wall_valid,
                                            epoch_seconds});
      if (!(start && busy)) begin
        if (pending_cmds.size() > 0 && !hold_off && $urandom_range(99) >= idle_pct)
        begin
          c = pending_cmds.pop_front();
          start <= 1'b1;
          op <= c.op; job_id <= c.job_id; time_value <= c.time_value;
          hour_utc <= c.hour_utc; minute_utc <= c.minute_utc; now_ms <= c.now_ms;
          wall_valid <= c.wall_valid; epoch_seconds <= c.epoch_seconds;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe beat is matched against the oldest prediction.
  always @(posedge clk) begin
    beat_t exp_b;
    if (!rst) begin
      if (strobe || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (strobe) begin
        if (expected_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected beat kind=%0d status=%0d id=%0d last=%0b",
                     kind, status, fired_job_id, last);
        end else begin
          exp_b = expected_beats.pop_front();
          if (exp_b != {kind, status, fired_job_id, last}) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected kind=%0d status=%0d id=%0d last=%0b, got kind=%0d status=%0d id=%0d last=%0b",
                       exp_b.kind, exp_b.status, exp_b.fired_job_id, exp_b.last,
                       kind, status, fired_job_id, last);
          end
        end
      end
      if (quiet_cycles > WatchdogLimit) begin
        $display("job_timer_table_tb: FAIL");
        $finish;
      end
    end
  end

  logic [31:0] clock_ms = 32'd1000;
  logic [31:0] wall_sec = 32'd1700000000;

  function automatic cmd_t mk_cmd(logic [2:0] o, logic [7:0] id, logic [31:0] tv,
                                  logic [7:0] hr, logic [7:0] mn);
    cmd_t c;
    c.op = o; c.job_id = id; c.time_value = tv; c.hour_utc = hr; c.minute_utc = mn;
    c.now_ms = clock_ms; c.wall_valid = 1'b1; c.epoch_seconds = wall_sec;
    return c;
  endfunction

  // Mostly well-formed traffic from a small id pool, with time moving forward.
  function automatic cmd_t random_cmd();
    cmd_t c;
    int r;
    r = $urandom_range(99);
    clock_ms += $urandom_range(3) == 0 ? $urandom : $urandom_range(300);
    wall_sec += $urandom_range(4) == 0 ? $urandom_range(200000) : $urandom_range(900);
    c = mk_cmd(jtt_pkg::OP_TICK, 8'($urandom_range(1, 24)), $urandom_range(600),
               8'($urandom_range(23)), 8'($urandom_range(59)));
    if (r < 35) c.op = jtt_pkg::OP_TICK;
    else if (r < 50) c.op = jtt_pkg::OP_ONE_SHOT;
    else if (r < 65) c.op = jtt_pkg::OP_PERIODIC;
    else if (r < 77) c.op = jtt_pkg::OP_DAILY;
    else if (r < 88) c.op = jtt_pkg::OP_CANCEL;
    else begin
      c.op = 3'($urandom);
      c.job_id = 8'($urandom);
      c.time_value = $urandom;
      c.hour_utc = 8'($urandom);
      c.minute_utc = 8'($urandom);
    end
    if ($urandom_range(9) == 0) c.now_ms = $urandom;
    if ($urandom_range(9) == 0) c.epoch_seconds = $urandom;
    c.wall_valid = $urandom_range(7) != 0;
    return c;
  endfunction

  initial begin
    cmd_t c;
    for (int i = 0; i < Slots; i++) free_slot(i);
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: argument checks, duplicates, a full table, cancels, wraps.
    pending_cmds.push_back(mk_cmd(jtt_pkg::OP_ONE_SHOT, 8'd0, 32'd5, 0, 0));
    pending_cmds.push_back(mk_cmd(jtt_pkg::OP_ONE_SHOT, 8'd1, 32'h8000_0000, 0, 0));
    pending_cmds.push_back(mk_cmd(jtt_pkg::OP_ONE_SHOT, 8'd255, 32'h7FFF_FFFF, 0, 0));
    pending_cmds.push_back(mk_cmd(jtt_pkg::OP_PERIODIC, 8'd2, 32'd0, 0, 0));
    pending_cmds.push_back(mk_cmd(jtt_pkg::OP_PERIODIC, 8'd2, 32'hFFFF_FFFF, 0, 0));
    pending_cmds.push_back(mk_cmd(jtt_pkg::OP_PERIODIC, 8'd2, 32'd1, 0, 0));
    pending_cmds.push_back(mk_cmd(jtt_pkg::OP_PERIODIC, 8'd2, 32'd7, 0, 0));
    pending_cmds.push_back(mk_cmd(jtt_pkg::OP_DAILY, 8'd3, 0, 8'd24, 8'd0));
    pending_cmds.push_back(mk_cmd(jtt_pkg::OP_DAILY, 8'd3, 0, 8'd0, 8'd60));
    pending_cmds.push_back(mk_cmd(jtt_pkg::OP_DAILY, 8'd3, 0, 8'd255, 8'd255));
    pending_cmds.push_back(mk_cmd(jtt_pkg::OP_DAILY, 8'd3, 0, 8'd23, 8'd59));
    pending_cmds.push_back(mk_cmd(jtt_pkg::OP_DAILY, 8'd4, 0, 8'd0, 8'd0));
    pending_cmds.push_back(mk_cmd(jtt_pkg::OP_CANCEL, 8'd0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(jtt_pkg::OP_CANCEL, 8'd99, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(jtt_pkg::OP_CANCEL, 8'd255, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(3'd5, 8'd1, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(3'd7, 8'd1, 0, 0, 0));
    for (int i = 10; i < 10 + Slots; i++)
      pending_cmds.push_back(mk_cmd(jtt_pkg::OP_ONE_SHOT, 8'(i), 32'd0, 0, 0));
    c = mk_cmd(jtt_pkg::OP_TICK, 0, 0, 0, 0);
    c.wall_valid = 1'b0;
    pending_cmds.push_back(c);
    c.now_ms = 32'hFFFF_FFFF; c.wall_valid = 1'b1; c.epoch_seconds = 32'hFFFF_FFFF;
    pending_cmds.push_back(c);
    c.now_ms = clock_ms + 32'h8000_0000;
    pending_cmds.push_back(c);

    // Random phases: light sender idling, heavy idling, then none.
    for (int ph = 0; ph < 3; ph++) begin
      wait (pending_cmds.size() == 0 && !start);
      if (ph == 1) begin
        hold_off = 1'b1;
        wait (expected_beats.size() == 0);
        hold_off = 1'b0;
      end
      idle_pct = (ph == 0) ? 8 : (ph == 1) ? 85 : 0;
      for (int n = 0; n < 160; n++) pending_cmds.push_back(random_cmd());
    end
    wait (pending_cmds.size() == 0 && !start);
    wait (expected_beats.size() == 0);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_beats.size() == 0)
      $display("job_timer_table_tb: PASS");
    else
      $display("job_timer_table_tb: FAIL");
    $finish;
  end

endmodule
